[src/vector_mean_contrast_stretch_macros.svh]
// Assertion macros shared by the block's modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef VECTOR_MEAN_CONTRAST_STRETCH_MACROS_SVH
`define VECTOR_MEAN_CONTRAST_STRETCH_MACROS_SVH

// Condition pre implies condition post in the same cycle.
`define VMCS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vmcs assertion failed");

// Condition pre implies condition post in the following cycle.
`define VMCS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vmcs assertion failed");

`endif

[src/vmcs_pkg.sv]
package vmcs_pkg;

    // Default sizes.
    localparam int PIXELS_DEF     = 4096;
    localparam int VECTOR_MAX_DEF = 256;

    // Fixed field widths.
    localparam int FEATURE_W = 32;
    localparam int INDEX_W   = 12;
    localparam int GRAY_W    = 8;
    localparam int GRAY_MAX  = 255;

    // Divider sizing: quotient bits per operation and the dividend width
    // that the stretch division needs.
    localparam int QUOT_W         = 32;
    localparam int MEAN_QBITS     = 32;
    localparam int STRETCH_QBITS  = 9;
    localparam int STRETCH_DIV_W  = 42;
    localparam int STRETCH_NUM_W  = 40;

    // Reset values of the running extremes.
    localparam logic signed [FEATURE_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [FEATURE_W-1:0] MAX_RESET = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_LOADED = 2'd1,
        STAT_FLAT       = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                         cmd;
        logic signed [FEATURE_W-1:0]  feature_value;
        logic                         last_in_vector;
        logic        [INDEX_W-1:0]    pixel_index;
    } in_word_t;

    typedef struct packed {
        logic [GRAY_W-1:0] stretched_value;
        status_t           status;
        logic              store_overflowed;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_SETUP,
        ST_MEAN_STORE,
        ST_READ_CHECK,
        ST_STRETCH_SETUP,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    // Divider start request; narrow selects the short stretch quotient.
    typedef struct packed {
        logic start;
        logic narrow;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[src/vmcs_divider.sv]
`include "vector_mean_contrast_stretch_macros.svh"

module vmcs_divider #(
    parameter int DIV_W = vmcs_pkg::STRETCH_DIV_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vmcs_pkg::div_ctl_t          ctl,
    input  logic [DIV_W-1:0]            dividend,
    input  logic [DIV_W-1:0]            divisor,
    output vmcs_pkg::div_stat_t         stat,
    output logic [vmcs_pkg::QUOT_W-1:0] quotient
);

    import vmcs_pkg::*;

    localparam int STEP_W = $clog2(MEAN_QBITS);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W-1:0]  diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The caller guarantees the quotient fits in the selected number of bits.
    always_comb
    begin
        diff      = rem_reg - dsh_reg;
        fits      = (rem_reg >= dsh_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = dividend;
            quot_next = '0;
            busy_next = 1'b1;
            if (ctl.narrow)
            begin
                dsh_next  = divisor << (STRETCH_QBITS - 1);
                step_next = STEP_W'(STRETCH_QBITS - 1);
            end
            else
            begin
                dsh_next  = divisor << (MEAN_QBITS - 1);
                step_next = STEP_W'(MEAN_QBITS - 1);
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = diff;
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

    `VMCS_ASSERT_NOW(a_no_start_while_busy, ctl.start, !busy_reg)
    `VMCS_ASSERT_NOW(a_done_means_idle, done_reg, !busy_reg)
    `VMCS_ASSERT_NEXT(a_last_step_finishes, busy_reg && (step_reg == '0) && !ctl.start, done_reg)

endmodule

[src/vector_mean_contrast_stretch.sv]
// Min/max contrast stretch of per-pixel feature-vector means. Push words add
// signed Q16.16 elements to the open vector (at most VECTOR_MAX are summed);
// the word flagged last closes the vector, its rounded mean goes to the next
// slot of a PIXELS-entry mean memory, and the running minimum and maximum are
// updated. A read word returns one result word: the stretched gray level of
// the requested pixel with a status (ok, index not loaded, flat range) and the
// sticky store-overflow flag. A clear word restarts everything and returns
// nothing. One word is processed at a time. Pushes that do not close a
// vector, clears and no-ops are taken in the idle state and stay there.
// Closing a vector holds off the next word until its mean is divided and
// stored. A read passes the check, setup, divide and result states, or
// goes from check straight to result for an unloaded index or flat range,
// and loads the output register in the result state. A read whose result
// finds the output register still stalled waits in the result state, and no
// new word is taken meanwhile. Both divisions use one shared bit-serial
// divider (32 quotient bits for a mean, 9 for a stretched level). The mean
// memory has one write and one registered read port; it needs no clearing.
`include "vector_mean_contrast_stretch_macros.svh"

module vector_mean_contrast_stretch #(
    parameter int PIXELS     = vmcs_pkg::PIXELS_DEF,
    parameter int VECTOR_MAX = vmcs_pkg::VECTOR_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  vmcs_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output vmcs_pkg::out_word_t result
);

    import vmcs_pkg::*;

    localparam int SUM_W  = FEATURE_W + $clog2(VECTOR_MAX);
    localparam int CNT_W  = $clog2(VECTOR_MAX + 1);
    localparam int SC_W   = $clog2(PIXELS + 1);
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CMP_W  = (SC_W > INDEX_W) ? SC_W : INDEX_W;
    localparam int DIV_W  = (SUM_W + 1 > STRETCH_DIV_W) ? SUM_W + 1 : STRETCH_DIV_W;

    state_t                       state_reg, state_next;

    logic signed [SUM_W-1:0]      sum_reg;
    logic        [CNT_W-1:0]      count_reg;
    logic        [SC_W-1:0]       stored_count_reg;
    logic signed [FEATURE_W-1:0]  min_reg;
    logic signed [FEATURE_W-1:0]  max_reg;
    logic                         overflow_reg;
    logic                         op_read_reg;
    logic                         loaded_reg;
    status_t                      read_status_reg;
    logic signed [FEATURE_W:0]    d_reg;
    logic signed [FEATURE_W:0]    den_reg;
    logic signed [FEATURE_W-1:0]  rd_data_reg;
    logic                         result_valid_reg;
    out_word_t                    result_word_reg;

    logic signed [FEATURE_W-1:0]  mean_store [PIXELS];

    logic                         accept;
    logic                         mem_we;
    logic                         result_load;
    logic                         room;
    div_ctl_t                     div_ctl;
    div_stat_t                    div_stat;
    logic [QUOT_W-1:0]            div_quot;
    logic [DIV_W-1:0]             div_dividend;
    logic [DIV_W-1:0]             div_divisor;
    logic [SUM_W-1:0]             sum_mag;
    logic [STRETCH_NUM_W-1:0]     stretch_num;
    logic signed [FEATURE_W-1:0]  mean_value;
    logic [GRAY_W-1:0]            gray_level;

    assign accept = item_valid && !item_stall;
    assign room   = (stored_count_reg < SC_W'(PIXELS));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_PUSH) && item.last_in_vector)
                begin
                    state_next = ST_MEAN_SETUP;
                end
                else if (accept && (item.cmd == CMD_READ))
                begin
                    state_next = ST_READ_CHECK;
                end
            end
            ST_MEAN_SETUP:
            begin
                state_next = ST_DIVIDE;
            end
            ST_READ_CHECK:
            begin
                if (!loaded_reg || (max_reg <= min_reg))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_STRETCH_SETUP;
                end
            end
            ST_STRETCH_SETUP:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = op_read_reg ? ST_RESULT : ST_MEAN_STORE;
                end
            end
            ST_MEAN_STORE:
            begin
                state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        item_stall     = 1'b1;
        div_ctl.start  = 1'b0;
        div_ctl.narrow = 1'b0;
        mem_we         = 1'b0;
        result_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_MEAN_SETUP:
            begin
                div_ctl.start = 1'b1;
            end
            ST_STRETCH_SETUP:
            begin
                div_ctl.start  = 1'b1;
                div_ctl.narrow = 1'b1;
            end
            ST_MEAN_STORE:
            begin
                mem_we = room;
            end
            ST_RESULT:
            begin
                result_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Divider operands: rounded mean |sum| + count/2 over count, or the
    // stretch 2*(d*255) + den over 2*den with d*255 built by shift and subtract.
    always_comb
    begin
        sum_mag     = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        stretch_num = d_reg[FEATURE_W] ? '0 :
                      ({d_reg[FEATURE_W-1:0], 8'b0} - STRETCH_NUM_W'(d_reg[FEATURE_W-1:0]));
        if (div_ctl.narrow)
        begin
            div_dividend = DIV_W'({stretch_num, 1'b0}) + DIV_W'(den_reg[FEATURE_W-1:0]);
            div_divisor  = DIV_W'({den_reg[FEATURE_W-1:0], 1'b0});
        end
        else
        begin
            div_dividend = DIV_W'(sum_mag) + DIV_W'(count_reg >> 1);
            div_divisor  = DIV_W'(count_reg);
        end
    end

    vmcs_divider #(
        .DIV_W (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Signed mean from the magnitude quotient, and the clamped gray level.
    always_comb
    begin
        mean_value = sum_reg[SUM_W-1] ? -signed'(div_quot) : signed'(div_quot);
        if (read_status_reg != STAT_OK)
        begin
            gray_level = '0;
        end
        else if (div_quot > QUOT_W'(GRAY_MAX))
        begin
            gray_level = GRAY_W'(GRAY_MAX);
        end
        else
        begin
            gray_level = div_quot[GRAY_W-1:0];
        end
    end

    // Control state: sequencer, accumulator, store fill, extremes, flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            stored_count_reg <= '0;
            min_reg          <= MIN_RESET;
            max_reg          <= MAX_RESET;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_load || (result_valid_reg && result_stall);
            if (accept && (item.cmd == CMD_PUSH) && (count_reg < CNT_W'(VECTOR_MAX)))
            begin
                sum_reg   <= sum_reg + SUM_W'(item.feature_value);
                count_reg <= count_reg + 1'b1;
            end
            if (accept && (item.cmd == CMD_CLEAR))
            begin
                sum_reg          <= '0;
                count_reg        <= '0;
                stored_count_reg <= '0;
                min_reg          <= MIN_RESET;
                max_reg          <= MAX_RESET;
                overflow_reg     <= 1'b0;
            end
            if (state_reg == ST_MEAN_STORE)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                if (room)
                begin
                    stored_count_reg <= stored_count_reg + 1'b1;
                    if (mean_value < min_reg)
                    begin
                        min_reg <= mean_value;
                    end
                    if (mean_value > max_reg)
                    begin
                        max_reg <= mean_value;
                    end
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
        end
    end

    // Read bookkeeping and stretch operands.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_read_reg <= (item.cmd == CMD_READ);
            loaded_reg  <= (CMP_W'(item.pixel_index) < CMP_W'(stored_count_reg));
        end
        if (state_reg == ST_READ_CHECK)
        begin
            if (!loaded_reg)
            begin
                read_status_reg <= STAT_NOT_LOADED;
            end
            else if (max_reg <= min_reg)
            begin
                read_status_reg <= STAT_FLAT;
            end
            else
            begin
                read_status_reg <= STAT_OK;
            end
            d_reg   <= (FEATURE_W + 1)'(rd_data_reg) - (FEATURE_W + 1)'(min_reg);
            den_reg <= (FEATURE_W + 1)'(max_reg) - (FEATURE_W + 1)'(min_reg);
        end
        if (result_load)
        begin
            result_word_reg.stretched_value  <= gray_level;
            result_word_reg.status           <= read_status_reg;
            result_word_reg.store_overflowed <= overflow_reg;
        end
    end

    // Mean memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mean_store[AW'(stored_count_reg)] <= mean_value;
        end
        if (accept && (item.cmd == CMD_READ))
        begin
            rd_data_reg <= mean_store[AW'(item.pixel_index)];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_word_reg;

    `VMCS_ASSERT_NOW(a_store_count_bounded, 1'b1, stored_count_reg <= SC_W'(PIXELS))
    `VMCS_ASSERT_NOW(a_divider_idle_outside_divide, state_reg != ST_DIVIDE, !div_stat.busy)
    `VMCS_ASSERT_NOW(a_write_only_with_room, mem_we, room)
    `VMCS_ASSERT_NEXT(a_clear_restarts, accept && (item.cmd == CMD_CLEAR), (stored_count_reg == '0) && !overflow_reg && (count_reg == '0))

endmodule
